// ===== rtl/rsc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rsc_pkg;

    // Field and syndrome sizes; the widths of the beat fields follow from them.
    localparam int SymbolBits   = 8;
    localparam int MaxSyndromes = 32;
    localparam int IndexBits    = 5;
    localparam int PolyBits     = SymbolBits + 1;
    localparam int ParityBits   = 6;
    localparam int CountBits    = $clog2(MaxSyndromes + 1);
    localparam int AddrBits     = 3;
    localparam int DataBits     = 32;

    typedef logic [SymbolBits-1:0] t_sym;

    typedef struct packed {
        t_sym symbol;
        logic block_end;
    } t_in_beat;

    typedef struct packed {
        t_sym                 syndrome_value;
        logic [IndexBits-1:0] syndrome_index;
        logic                 no_errors;
        logic                 last_syndrome;
    } t_out_beat;

    // Per-cycle controls broadcast to every cell of the chain.
    typedef struct packed {
        logic step;
        logic load;
        logic shift;
    } t_cell_ctrl;

    // Register file contents seen by the datapath.
    typedef struct packed {
        logic [PolyBits-1:0]   field_poly;
        logic [ParityBits-1:0] parity_symbols;
        logic                  poly_write;
    } t_cfg;

    typedef enum logic {
        REG_FIELD_POLY = 1'b0,
        REG_PARITY     = 1'b1
    } t_reg_index;

    localparam logic [PolyBits-1:0]   FieldPolyReset = PolyBits'(285);
    localparam logic [ParityBits-1:0] ParityReset    = ParityBits'(16);

    // Multiply by x, reducing by the programmed polynomial.
    function automatic t_sym gf_times_x(input t_sym v, input logic [PolyBits-1:0] poly);
        logic [SymbolBits:0] s;
        s = {v, 1'b0};
        if (s[SymbolBits]) begin
            s = s ^ poly;
        end
        return s[SymbolBits-1:0];
    endfunction

    // General field multiply, MSB-first shift and add.
    function automatic t_sym gf_mul(input t_sym a, input t_sym b,
                                    input logic [PolyBits-1:0] poly);
        t_sym p;
        p = '0;
        for (int i = SymbolBits - 1; i >= 0; i--) begin
            p = gf_times_x(p, poly);
            if (a[i]) begin
                p = p ^ b;
            end
        end
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rsc_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rsc_cell (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire rsc_pkg::t_cell_ctrl          i_ctrl,
    input  wire logic [rsc_pkg::PolyBits-1:0] i_poly,
    input  wire rsc_pkg::t_sym                i_sym,
    input  wire logic                         i_in_range,
    input  wire rsc_pkg::t_sym                i_pow_prev,
    output rsc_pkg::t_sym                     o_pow,
    input  wire rsc_pkg::t_sym                i_sh_next,
    output rsc_pkg::t_sym                     o_sh,
    output logic                              o_nz
);
    import rsc_pkg::*;

    t_sym r_pow;
    t_sym r_acc;
    t_sym r_sh;
    logic r_nz;
    t_sym n_acc;

    // This cell's evaluation point is its left neighbor's point times x.
    always_ff @(posedge i_clk) begin
        r_pow <= gf_times_x(i_pow_prev, i_poly);
    end

    assign n_acc = gf_mul(r_acc, r_pow, i_poly) ^ i_sym;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_nz  <= 1'b0;
        end else if (i_ctrl.step) begin
            r_acc <= i_ctrl.load ? '0 : n_acc;
            if (i_ctrl.load) begin
                r_nz <= i_in_range && (n_acc != '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_sh <= n_acc;
        end else if (i_ctrl.shift) begin
            r_sh <= i_sh_next;
        end
    end

    assign o_pow = r_pow;
    assign o_sh  = r_sh;
    assign o_nz  = r_nz;

endmodule

`default_nettype wire

// ===== rtl/rsc_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rsc_regs (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [rsc_pkg::AddrBits-1:0] paddr,
    input  wire logic [rsc_pkg::DataBits-1:0] pwdata,
    output logic      [rsc_pkg::DataBits-1:0] prdata,
    output logic                              pready,
    output rsc_pkg::t_cfg                     o_cfg
);
    import rsc_pkg::*;

    logic [PolyBits-1:0]   r_poly;
    logic [ParityBits-1:0] r_parity;
    logic                  r_poly_write;
    logic                  w_write;
    t_reg_index            w_index;

    assign w_write = psel && penable && pwrite;
    assign w_index = t_reg_index'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly       <= FieldPolyReset;
            r_parity     <= ParityReset;
            r_poly_write <= 1'b0;
        end else begin
            r_poly_write <= 1'b0;
            if (w_write) begin
                unique case (w_index)
                    REG_FIELD_POLY: begin
                        r_poly       <= pwdata[PolyBits-1:0];
                        r_poly_write <= 1'b1;
                    end
                    REG_PARITY: begin
                        r_parity <= pwdata[ParityBits-1:0];
                    end
                endcase
            end
        end
    end

    always_comb begin
        unique case (w_index)
            REG_FIELD_POLY: prdata = DataBits'(r_poly);
            REG_PARITY:     prdata = DataBits'(r_parity);
        endcase
    end

    assign pready               = 1'b1;
    assign o_cfg.field_poly     = r_poly;
    assign o_cfg.parity_symbols = r_parity;
    assign o_cfg.poly_write     = r_poly_write;

endmodule

`default_nettype wire

// ===== rtl/rs_syndrome_calculator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Reed-Solomon syndrome calculator over GF(2^8).
// Input channel (i_in_valid / o_in_ready / i_in): one code symbol per beat, highest
// degree first; block_end marks the degree-zero symbol. Output channel (o_out_valid /
// i_out_ready / o_out): the 2t syndromes of a block, one per beat, in index order.
// A row of 32 identical cells holds one accumulator each and updates it with one
// field multiply per accepted beat, so symbols are taken one per cycle unless the
// input is held off. The first syndrome is offered the cycle after the block_end
// beat is taken; the rest follow one per cycle while the receiver is ready, from a
// shadow shift chain while the cells already take the next block. Each cell
// registers its evaluation point from its neighbor's, so the input is held off
// while the points settle along the chain after reset and after every write of
// field_poly. Beyond that, a block_end beat waits only while the previous block's
// syndromes are still being delivered, so with a stalled receiver the input keeps
// running until the next block end. Reset clears the accumulators and the output
// channel. APB registers: field_poly at address 0, parity_symbols at address 4.
module rs_syndrome_calculator (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire rsc_pkg::t_in_beat            i_in,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output rsc_pkg::t_out_beat                o_out,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [rsc_pkg::AddrBits-1:0] paddr,
    input  wire logic [rsc_pkg::DataBits-1:0] pwdata,
    output logic      [rsc_pkg::DataBits-1:0] prdata,
    output logic                              pready
);
    import rsc_pkg::*;

    t_cfg                  w_cfg;
    t_cell_ctrl            w_ctrl;
    t_sym                  w_pow [MaxSyndromes+1];
    t_sym                  w_sh  [MaxSyndromes+1];
    logic [MaxSyndromes-1:0] w_nz;
    logic [ParityBits-1:0] w_even;
    logic [CountBits-1:0]  w_count;
    logic                  w_in_fire;
    logic                  w_out_fire;
    logic                  w_last;

    logic [CountBits-1:0]  r_settle;
    logic                  r_busy;
    logic [IndexBits-1:0]  r_idx;
    logic [IndexBits-1:0]  r_last_idx;

    rsc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Syndrome count: parity count rounded down to even, capped at the cell count.
    assign w_even  = {w_cfg.parity_symbols[ParityBits-1:1], 1'b0};
    assign w_count = (w_even > ParityBits'(MaxSyndromes)) ? CountBits'(MaxSyndromes)
                                                          : CountBits'(w_even);

    assign w_last     = (r_idx == r_last_idx);
    assign w_out_fire = o_out_valid && i_out_ready;
    assign w_in_fire  = i_in_valid && o_in_ready;

    // A block end may enter while the final syndrome of the previous block leaves.
    // The cycle right after a polynomial write still sees the old points, so it is
    // held off as well.
    assign o_in_ready = (r_settle == '0) && !w_cfg.poly_write
                     && (!r_busy || !i_in.block_end || (w_out_fire && w_last));

    assign w_ctrl.step  = w_in_fire;
    assign w_ctrl.load  = w_in_fire && i_in.block_end;
    assign w_ctrl.shift = w_out_fire;

    // The leftmost cell sees the field element one; its point is then x.
    assign w_pow[0]           = SymbolBits'(1);
    assign w_sh[MaxSyndromes] = '0;

    for (genvar j = 0; j < MaxSyndromes; j++) begin : g_cell
        rsc_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (w_ctrl),
            .i_poly     (w_cfg.field_poly),
            .i_sym      (i_in.symbol),
            .i_in_range (CountBits'(j) < w_count),
            .i_pow_prev (w_pow[j]),
            .o_pow      (w_pow[j+1]),
            .i_sh_next  (w_sh[j+1]),
            .o_sh       (w_sh[j]),
            .o_nz       (w_nz[j])
        );
    end

    // Settling counter for the evaluation points after reset or a new polynomial.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_cfg.poly_write) begin
            r_settle <= CountBits'(MaxSyndromes);
        end else if (r_settle != '0) begin
            r_settle <= r_settle - 1'b1;
        end
    end

    // Output sequencing over the shadow chain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_idx      <= '0;
            r_last_idx <= '0;
        end else if (w_ctrl.load && (w_count != '0)) begin
            r_busy     <= 1'b1;
            r_idx      <= '0;
            r_last_idx <= IndexBits'(w_count - 1'b1);
        end else if (w_out_fire) begin
            if (w_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    assign o_out_valid          = r_busy;
    assign o_out.syndrome_value = w_sh[0];
    assign o_out.syndrome_index = r_idx;
    assign o_out.no_errors      = ~|w_nz;
    assign o_out.last_syndrome  = w_last;

    // A block end taken while busy must coincide with the final syndrome leaving.
    a_end_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && i_in.block_end && r_busy) |-> (w_out_fire && w_last))
        else $error("block end accepted while syndromes still pending");

    // After the final syndrome leaves with no new block, the channel goes quiet.
    a_drain_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_fire && w_last && !w_ctrl.load) |=> !o_out_valid)
        else $error("output still valid after final syndrome");

    // The running index never passes the final index of the run.
    a_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_idx <= r_last_idx))
        else $error("syndrome index beyond syndrome count");

    // No symbol enters while the evaluation points are settling.
    a_settle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_settle != '0) |-> !o_in_ready)
        else $error("input accepted before evaluation points settled");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the Reed-Solomon syndrome calculator.
//
// Symbols go in on the input channel, highest degree first. Each symbol is fed at the
// moment it is taken to a Horner predictor in this file. That predictor keeps its own
// accumulators and its own copy of the two registers. On a block end it queues the
// 2t syndrome beats that the block must return. The output monitor pops the oldest of
// those beats for every syndrome beat that is taken and compares it field by field.
//
// The run has two parts. The first is a short directed plan that walks the register
// extremes: a syndrome count of zero from both small parity values, the saturated
// count, a malformed polynomial and a bare shift polynomial. The second part is a set
// of random phases. Most of their blocks are true codewords built from a generator
// polynomial of the current setting, so the all-zero flag is really exercised. Some of
// those codewords carry one corrupted symbol, and the rest of the blocks are noise.
module tb;
    import rsc_pkg::*;

    localparam int QUIET_CYCLES    = 40;    // covers the point settling chain
    localparam int LONG_HOLD       = 150;   // receiver back-pressure stretch
    localparam int WATCHDOG_LIMIT  = 2000;  // cycles without any accepted beat
    localparam int RAND_PHASES     = 8;
    localparam int ITEMS_PER_PHASE = 6;
    localparam int HOLD_PHASE      = 2;
    localparam int MAX_MSG         = 6;
    localparam int PLAN_ROWS       = 30;

    typedef enum logic {
        ROW_BEAT,
        ROW_WRITE
    } t_plan_kind;

    // One row of the directed plan: either a register write or one symbol beat. A
    // block-end beat may carry a typed syndrome value when every syndrome of that
    // block is obvious (a single symbol after a clear, or an all-zero block).
    typedef struct packed {
        t_plan_kind  kind;
        t_reg_index  reg_sel;
        int unsigned reg_val;
        t_sym        sym;
        logic        blk_end;
        logic        typed;
        t_sym        typed_syn;
    } t_plan_row;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                in_valid = 1'b0;
    t_in_beat            in_beat  = '0;
    logic                out_ready = 1'b0;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [AddrBits-1:0] paddr    = '0;
    logic [DataBits-1:0] pwdata   = '0;

    logic                o_in_ready;
    logic                o_out_valid;
    t_out_beat           o_out;
    logic [DataBits-1:0] prdata;
    logic                pready;

    // Predictor state: register copies and one Horner accumulator per syndrome.
    logic [PolyBits-1:0]   poly_setting   = FieldPolyReset;
    logic [ParityBits-1:0] parity_setting = ParityReset;
    t_sym                  horner_acc [MaxSyndromes];
    t_out_beat             expected_syndromes [$];

    t_sym      block_syms [$];
    t_plan_row plan [PLAN_ROWS];
    logic [PolyBits-1:0] prim_polys [16];

    logic      idle_on     = 1'b1;
    int        hold_asks   = 0;
    int        hold_served = 0;
    int        stall_left  = 0;
    int        idle_cycles = 0;
    t_out_beat oldest;

    int fail_count        = 0;
    int symbols_sent      = 0;
    int blocks_closed     = 0;
    int syndromes_checked = 0;
    int settings_written  = 0;

    rs_syndrome_calculator u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out       (o_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Multiply by x in the ring set by the programmed polynomial. Nothing checks that
    // the polynomial is primitive, so malformed ones simply give a different ring.
    function automatic t_sym times_x(input t_sym v);
        return {v[SymbolBits-2:0], 1'b0} ^
               (v[SymbolBits-1] ? poly_setting[SymbolBits-1:0] : t_sym'(0));
    endfunction

    // Shift-and-add multiply, low bit of b first. It is only used to build codewords.
    function automatic t_sym field_mul(input t_sym a, input t_sym b);
        t_sym sum;
        t_sym shifted;
        sum = '0;
        shifted = a;
        for (int i = 0; i < SymbolBits; i++) begin
            if (b[i]) begin
                sum ^= shifted;
            end
            shifted = times_x(shifted);
        end
        return sum;
    endfunction

    // 2t: the parity count rounded down to even, capped at the accumulator count.
    function automatic int syndromes_per_block();
        int n;
        n = int'(parity_setting) & ~1;
        if (n > (MaxSyndromes & ~1)) begin
            n = MaxSyndromes & ~1;
        end
        return n;
    endfunction

    // Horner step on every accumulator. On a block end, queue the 2t syndrome beats
    // and clear all accumulators, including those past 2t that were never emitted.
    function automatic void absorb_symbol(input t_sym sym, input logic blk_end,
                                          input logic typed, input t_sym typed_syn);
        t_sym      v;
        t_out_beat beat;
        int        n;
        logic      clean;
        for (int j = 0; j < MaxSyndromes; j++) begin
            v = horner_acc[j];
            for (int k = 0; k <= j; k++) begin
                v = times_x(v);
            end
            horner_acc[j] = v ^ sym;
        end
        if (blk_end) begin
            n = syndromes_per_block();
            clean = 1'b1;
            for (int j = 0; j < n; j++) begin
                if ((typed ? typed_syn : horner_acc[j]) != '0) begin
                    clean = 1'b0;
                end
            end
            for (int j = 0; j < n; j++) begin
                beat.syndrome_value = typed ? typed_syn : horner_acc[j];
                beat.syndrome_index = IndexBits'(j);
                beat.no_errors      = clean;
                beat.last_syndrome  = (j == n - 1);
                expected_syndromes = {expected_syndromes, beat};
            end
            foreach (horner_acc[j]) begin
                horner_acc[j] = '0;
            end
            blocks_closed++;
        end
    endfunction

    // Codeword = random message times the generator whose roots are x^1 .. x^(2t).
    // The symbols are left in block_syms, highest degree first.
    function automatic void encode_block(input int msg_len);
        t_sym gen [MaxSyndromes+1];
        t_sym prod [MaxSyndromes+MAX_MSG];
        t_sym root;
        t_sym coef;
        int   n;
        n = syndromes_per_block();
        foreach (gen[i]) begin
            gen[i] = '0;
        end
        foreach (prod[i]) begin
            prod[i] = '0;
        end
        gen[0] = t_sym'(1);
        root = t_sym'(1);
        for (int j = 0; j < n; j++) begin
            root = times_x(root);
            for (int i = j + 1; i > 0; i--) begin
                gen[i] = gen[i-1] ^ field_mul(root, gen[i]);
            end
            gen[0] = field_mul(root, gen[0]);
        end
        for (int k = 0; k < msg_len; k++) begin
            coef = t_sym'($urandom_range(0, 255));
            for (int i = 0; i <= n; i++) begin
                prod[k+i] ^= field_mul(coef, gen[i]);
            end
        end
        block_syms.delete();
        for (int d = msg_len + n - 1; d >= 0; d--) begin
            block_syms = {block_syms, prod[d]};
        end
    endfunction

    // Offer one symbol beat, with an occasional gap first, and hold it until it is
    // taken. The task returns in the time step of the accepting edge.
    task automatic send_beat(input t_sym sym, input logic blk_end,
                             input logic typed, input t_sym typed_syn);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= '{symbol: sym, block_end: blk_end};
        do @(posedge clk); while (!o_in_ready);
        symbols_sent++;
        absorb_symbol(sym, blk_end, typed, typed_syn);
    endtask

    // Stop sending, let every expected syndrome drain, then allow for the settling
    // chain and any block that ended with no syndromes at all.
    task automatic quiesce();
        in_valid <= 1'b0;
        while (expected_syndromes.size() != 0) @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic read_reg(input t_reg_index idx, input logic [DataBits-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= AddrBits'(4 * int'(idx));
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== want) begin
            $error("%s readback: expected %0d, actual %0d", idx.name(), want, prdata);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Setup cycle, access cycle, then a readback of the value just written.
    task automatic write_reg(input t_reg_index idx, input int unsigned val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AddrBits'(4 * int'(idx));
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (idx == REG_FIELD_POLY) begin
            poly_setting = PolyBits'(val);
        end else begin
            parity_setting = ParityBits'(val);
        end
        settings_written++;
        read_reg(idx, val);
    endtask

    // Output side: check each syndrome beat against the oldest expectation, then pick
    // ready for the next cycle. When the stimulus asks for it, a long hold is served;
    // otherwise there are short random stalls while idling is on.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (expected_syndromes.size() == 0) begin
                    $error("syndrome beat with none expected: value %0d index %0d",
                           o_out.syndrome_value, o_out.syndrome_index);
                    fail_count++;
                end else begin
                    oldest = expected_syndromes.pop_front();
                    if (o_out.syndrome_value !== oldest.syndrome_value) begin
                        $error("syndrome_value: expected %0d, actual %0d",
                               oldest.syndrome_value, o_out.syndrome_value);
                        fail_count++;
                    end
                    if (o_out.syndrome_index !== oldest.syndrome_index) begin
                        $error("syndrome_index: expected %0d, actual %0d",
                               oldest.syndrome_index, o_out.syndrome_index);
                        fail_count++;
                    end
                    if (o_out.no_errors !== oldest.no_errors) begin
                        $error("no_errors: expected %0d, actual %0d",
                               oldest.no_errors, o_out.no_errors);
                        fail_count++;
                    end
                    if (o_out.last_syndrome !== oldest.last_syndrome) begin
                        $error("last_syndrome: expected %0d, actual %0d",
                               oldest.last_syndrome, o_out.last_syndrome);
                        fail_count++;
                    end
                    syndromes_checked++;
                end
            end
            if (stall_left != 0) begin
                out_ready  <= 1'b0;
                stall_left <= stall_left - 1;
            end else if (hold_served != hold_asks) begin
                hold_served <= hold_asks;
                out_ready   <= 1'b0;
                stall_left  <= LONG_HOLD - 1;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                out_ready  <= 1'b0;
                stall_left <= $urandom_range(0, 3);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: a run that stops moving beats on both channels is a failure.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("No beat accepted for %0d cycles.", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int unsigned new_poly;
        int unsigned new_parity;
        int          phase_items;
        int          shape;
        int          pos;

        foreach (horner_acc[j]) begin
            horner_acc[j] = '0;
        end
        prim_polys = '{9'd285, 9'd299, 9'd301, 9'd333, 9'd351, 9'd355, 9'd357, 9'd361,
                       9'd369, 9'd391, 9'd397, 9'd425, 9'd451, 9'd463, 9'd487, 9'd501};

        // Directed plan. The first blocks run with the reset settings. Parity 0 and 1
        // give no syndromes but still clear. Parity 63 saturates at 32 syndromes, with
        // the all-ones polynomial. Parity 3 rounds down to two syndromes, with a
        // polynomial that is only the top term, so the multiply by x is a bare shift.
        plan = '{
            '{ROW_BEAT,  REG_FIELD_POLY, 32'd0,   8'h00, 1'b1, 1'b1, 8'h00},
            '{ROW_BEAT,  REG_FIELD_POLY, 32'd0,   8'hFF, 1'b1, 1'b1, 8'hFF},
            '{ROW_BEAT,  REG_FIELD_POLY, 32'd0,   8'h01, 1'b0, 1'b0, 8'h00},
            '{ROW_BEAT,  REG_FIELD_POLY, 32'd0,   8'h80, 1'b0, 1'b0, 8'h00},
            '{ROW_BEAT,  REG_FIELD_POLY, 32'd0,   8'hAA, 1'b0, 1'b0, 8'h00},
            '{ROW_BEAT,  REG_FIELD_POLY, 32'd0,   8'h55, 1'b1, 1'b0, 8'h00},
            '{ROW_WRITE, REG_PARITY,     32'd0,   8'h00, 1'b0, 1'b0, 8'h00},
            '{ROW_BEAT,  REG_FIELD_POLY, 32'd0,   8'h3C, 1'b0, 1'b0, 8'h00},
            '{ROW_BEAT,  REG_FIELD_POLY, 32'd0,   8'hC3, 1'b1, 1'b0, 8'h00},
            '{ROW_WRITE, REG_PARITY,     32'd1,   8'h00, 1'b0, 1'b0, 8'h00},
            '{ROW_BEAT,  REG_FIELD_POLY, 32'd0,   8'h12, 1'b0, 1'b0, 8'h00},
            '{ROW_BEAT,  REG_FIELD_POLY, 32'd0,   8'h34, 1'b1, 1'b0, 8'h00},
            '{ROW_WRITE, REG_PARITY,     32'd63,  8'h00, 1'b0, 1'b0, 8'h00},
            '{ROW_WRITE, REG_FIELD_POLY, 32'd511, 8'h00, 1'b0, 1'b0, 8'h00},
            '{ROW_BEAT,  REG_FIELD_POLY, 32'd0,   8'h5A, 1'b1, 1'b1, 8'h5A},
            '{ROW_BEAT,  REG_FIELD_POLY, 32'd0,   8'hFF, 1'b0, 1'b0, 8'h00},
            '{ROW_BEAT,  REG_FIELD_POLY, 32'd0,   8'hFF, 1'b0, 1'b0, 8'h00},
            '{ROW_BEAT,  REG_FIELD_POLY, 32'd0,   8'h81, 1'b1, 1'b0, 8'h00},
            '{ROW_WRITE, REG_PARITY,     32'd3,   8'h00, 1'b0, 1'b0, 8'h00},
            '{ROW_WRITE, REG_FIELD_POLY, 32'd256, 8'h00, 1'b0, 1'b0, 8'h00},
            '{ROW_BEAT,  REG_FIELD_POLY, 32'd0,   8'h80, 1'b0, 1'b0, 8'h00},
            '{ROW_BEAT,  REG_FIELD_POLY, 32'd0,   8'h01, 1'b0, 1'b0, 8'h00},
            '{ROW_BEAT,  REG_FIELD_POLY, 32'd0,   8'hF0, 1'b1, 1'b0, 8'h00},
            '{ROW_BEAT,  REG_FIELD_POLY, 32'd0,   8'h00, 1'b0, 1'b0, 8'h00},
            '{ROW_BEAT,  REG_FIELD_POLY, 32'd0,   8'h00, 1'b1, 1'b1, 8'h00},
            '{ROW_WRITE, REG_FIELD_POLY, 32'd285, 8'h00, 1'b0, 1'b0, 8'h00},
            '{ROW_WRITE, REG_PARITY,     32'd32,  8'h00, 1'b0, 1'b0, 8'h00},
            '{ROW_BEAT,  REG_FIELD_POLY, 32'd0,   8'h0F, 1'b0, 1'b0, 8'h00},
            '{ROW_BEAT,  REG_FIELD_POLY, 32'd0,   8'hF0, 1'b0, 1'b0, 8'h00},
            '{ROW_BEAT,  REG_FIELD_POLY, 32'd0,   8'h99, 1'b1, 1'b0, 8'h00}
        };

        // Synchronous reset, then confirm the reset register values.
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        read_reg(REG_FIELD_POLY, DataBits'(FieldPolyReset));
        read_reg(REG_PARITY, DataBits'(ParityReset));

        foreach (plan[r]) begin
            if (plan[r].kind == ROW_WRITE) begin
                quiesce();
                write_reg(plan[r].reg_sel, plan[r].reg_val);
            end else begin
                send_beat(plan[r].sym, plan[r].blk_end, plan[r].typed, plan[r].typed_syn);
            end
        end

        // Random phases. Each one picks a polynomial (mostly primitive) and a parity
        // count (mostly small, with the odd zero-syndrome or large setting) and then
        // sends whole blocks. One phase asks the receiver for a long hold and sends at
        // least two blocks, so that the block fills up behind a pending block end. The
        // last phase runs without gaps.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            quiesce();
            if (ph == RAND_PHASES - 1) begin
                idle_on <= 1'b0;
            end
            if ($urandom_range(0, 2) == 0) begin
                new_poly = $urandom_range(256, 511);
            end else begin
                new_poly = 32'(prim_polys[$urandom_range(0, 15)]);
            end
            case ($urandom_range(0, 7))
                0: begin
                    new_parity = $urandom_range(0, 1);
                end
                1: begin
                    new_parity = $urandom_range(9, 63);
                end
                default: begin
                    new_parity = $urandom_range(2, 8);
                end
            endcase
            if (ph == HOLD_PHASE) begin
                new_parity = 4;
            end
            write_reg(REG_FIELD_POLY, new_poly);
            write_reg(REG_PARITY, new_parity);
            if (ph == HOLD_PHASE) begin
                hold_asks <= hold_asks + 1;
            end

            phase_items = 0;
            while (phase_items < (ph == HOLD_PHASE ? 2 * ITEMS_PER_PHASE
                                                   : ITEMS_PER_PHASE)) begin
                shape = $urandom_range(0, 9);
                if (shape < 2) begin
                    // Noise: a short block of arbitrary symbols.
                    block_syms.delete();
                    repeat ($urandom_range(1, MAX_MSG)) begin
                        block_syms = {block_syms, t_sym'($urandom_range(0, 255))};
                    end
                end else begin
                    encode_block($urandom_range(1, MAX_MSG));
                    if (shape < 4) begin
                        // A single corrupted symbol anywhere in the codeword.
                        pos = $urandom_range(0, block_syms.size() - 1);
                        block_syms[pos] ^= t_sym'($urandom_range(1, 255));
                    end
                end
                foreach (block_syms[i]) begin
                    send_beat(block_syms[i], i == block_syms.size() - 1, 1'b0, '0);
                end
                phase_items += block_syms.size();
            end
        end

        quiesce();
        $display("Run covered %0d symbols in %0d blocks and %0d register writes.",
                 symbols_sent, blocks_closed, settings_written);
        $display("Compared %0d syndrome beats field by field.", syndromes_checked);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
